@@ rtl/core/terminal_line_editor_unit_macros.svh @@
// Assertion shorthands for the checker file.
`ifndef TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH
`define TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/tle_pkg.sv @@
package tle_pkg;

   localparam int RING_SLOTS_DEFAULT = 128;

   localparam logic [2:0] KIND_ECHO    = 3'd0;
   localparam logic [2:0] KIND_BELL    = 3'd1;
   localparam logic [2:0] KIND_CRLF    = 3'd2;
   localparam logic [2:0] KIND_ERASE   = 3'd3;
   localparam logic [2:0] KIND_DATA    = 3'd4;
   localparam logic [2:0] KIND_EMPTY   = 3'd5;
   localparam logic [2:0] KIND_REFUSED = 3'd6;

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic [7:0] CHAR_BS   = 8'h08;
   localparam logic [7:0] CHAR_DEL  = 8'h7F;
   localparam logic [7:0] CHAR_ETB  = 8'h17;
   localparam logic [7:0] CHAR_NAK  = 8'h15;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_BEL  = 8'h07;
   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_SP   = 8'h20;

   typedef struct packed {
      logic       action;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_out;
      logic [6:0] erase_count;
   } rsp_type;

   function automatic logic is_white(input logic [7:0] c);
      return (c == CHAR_SP) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

@@ rtl/core/terminal_line_editor_unit.sv @@
// Channel  Dir  Handshake            Word
// req      in   req_valid/req_ready  tle_pkg::req_type (action, char_in)
// rsp      out  rsp_valid/rsp_ready  tle_pkg::rsp_type (kind, byte_out, erase_count)
//
// One word at a time. A plain character, CR, backspace, Ctrl-U, refusal or empty read
// goes from idle straight to the done state; a read pop first passes the read state.
// Ctrl-W walks the ring one entry per cycle, one step per erased character, plus one
// step when it stops on whitespace; the walk stops at the read pointer.
// Synchronous reset empties the ring pointers and returns to editing mode; no clearing pass.
// A result waits in the output register; req_ready returns as soon as the unit is idle,
// and a finished item stalls only if the previous result has not been taken.
module terminal_line_editor_unit #(
   parameter int RING_SLOTS = tle_pkg::RING_SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tle_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(RING_SLOTS);
   localparam int CW    = (PTR_W > 7) ? PTR_W : 7;
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(RING_SLOTS - 1);
   localparam logic [PTR_W-1:0] FULL_LEN   = PTR_W'(RING_SLOTS - 2);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_WORD = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [7:0] line_store_ff [RING_SLOTS];
   logic [7:0] rdata_ff;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic             complete_ff, complete_in;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tle_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             mem_we, mem_re;
   logic [PTR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_wdata;

   logic [PTR_W:0]   diff;
   logic [PTR_W-1:0] len;
   logic             complete_eff;
   logic             req_fire;
   logic [PTR_W-1:0] wr_prev, wr_prev2, wr_next, rd_next;
   logic [CW-1:0]    cnt_wide;
   logic [6:0]       cnt_sat;

   function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : PTR_W'(p - 1'b1);
   endfunction

   assign diff = {1'b0, wr_ff} - {1'b0, rd_ff};
   assign len  = diff[PTR_W] ? PTR_W'(diff + (PTR_W+1)'(RING_SLOTS)) : diff[PTR_W-1:0];

   // A completed line with nothing left counts as editing.
   assign complete_eff = complete_ff && (len != '0);

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign wr_prev  = slot_prev(wr_ff);
   assign wr_prev2 = slot_prev(wr_prev);
   assign wr_next  = slot_next(wr_ff);
   assign rd_next  = slot_next(rd_ff);

   assign cnt_wide = CW'(count_ff);
   assign cnt_sat  = (cnt_wide > CW'(127)) ? 7'd127 : cnt_wide[6:0];

   // Writes happen only on accepting a character, and no read is issued in that cycle,
   // so a read never meets a write to the same slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= line_store_ff[mem_raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      complete_in  = complete_eff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      count_in     = count_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_ff;
      mem_wdata    = req_data.char_in;
      mem_re       = 1'b0;
      mem_raddr    = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               byte_in  = '0;
               count_in = '0;
               state_in = S_DONE;
               priority if (req_data.action == tle_pkg::ACTION_READ) begin
                  if (!complete_eff) begin
                     kind_in = tle_pkg::KIND_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = rd_ff;
                     state_in  = S_READ;
                  end
               end else if (complete_eff) begin
                  kind_in = tle_pkg::KIND_REFUSED;
               end else if (req_data.char_in == tle_pkg::CHAR_CR) begin
                  mem_we      = 1'b1;
                  mem_wdata   = tle_pkg::CHAR_LF;
                  wr_in       = wr_next;
                  complete_in = 1'b1;
                  kind_in     = tle_pkg::KIND_CRLF;
                  byte_in     = tle_pkg::CHAR_CR;
               end else if (req_data.char_in == tle_pkg::CHAR_BS ||
                            req_data.char_in == tle_pkg::CHAR_DEL) begin
                  if (len == '0) begin
                     kind_in = tle_pkg::KIND_BELL;
                     byte_in = tle_pkg::CHAR_BEL;
                  end else begin
                     wr_in    = wr_prev;
                     kind_in  = tle_pkg::KIND_ERASE;
                     count_in = PTR_W'(1);
                  end
               end else if (req_data.char_in == tle_pkg::CHAR_ETB) begin
                  kind_in = tle_pkg::KIND_ERASE;
                  if (len != '0) begin
                     mem_re    = 1'b1;
                     mem_raddr = wr_prev;
                     state_in  = S_WORD;
                  end
               end else if (req_data.char_in == tle_pkg::CHAR_NAK) begin
                  kind_in  = tle_pkg::KIND_ERASE;
                  count_in = len;
                  wr_in    = rd_ff;
               end else if (len >= FULL_LEN) begin
                  kind_in = tle_pkg::KIND_BELL;
                  byte_in = tle_pkg::CHAR_BEL;
               end else begin
                  mem_we  = 1'b1;
                  wr_in   = wr_next;
                  kind_in = tle_pkg::KIND_ECHO;
                  byte_in = req_data.char_in;
               end
            end
         end
         S_READ: begin
            kind_in  = tle_pkg::KIND_DATA;
            byte_in  = rdata_ff;
            rd_in    = rd_next;
            if (rd_next == wr_ff) begin
               complete_in = 1'b0;
            end
            state_in = S_DONE;
         end
         S_WORD: begin
            // rdata_ff holds the byte before the cursor; fetch the next one ahead.
            if (tle_pkg::is_white(rdata_ff)) begin
               state_in = S_DONE;
            end else begin
               wr_in    = wr_prev;
               count_in = PTR_W'(count_ff + 1'b1);
               if (wr_prev == rd_ff) begin
                  state_in = S_DONE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = wr_prev2;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = kind_ff;
               rsp_data_in.byte_out    = byte_ff;
               rsp_data_in.erase_count = cnt_sat;
               state_in                = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ff        <= '0;
         rd_ff        <= '0;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/tle_checker.sv @@
`include "terminal_line_editor_unit_macros.svh"

module tle_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tle_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tle_pkg::rsp_type rsp_data
);

   // Hold a stalled result word.
   `TLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // One word in flight: drop ready right after an accept.
   `TLE_ASSERT_NEXT(a_one_word, req_valid && req_ready, !req_ready, "req accepted while busy")

   `TLE_ASSERT_NOW(a_count_erase_only, rsp_valid && rsp_data.kind != tle_pkg::KIND_ERASE, rsp_data.erase_count == 7'd0, "erase count outside an erase")

   `TLE_ASSERT_NOW(a_byte_zero, rsp_valid && (rsp_data.kind == tle_pkg::KIND_ERASE || rsp_data.kind == tle_pkg::KIND_EMPTY || rsp_data.kind == tle_pkg::KIND_REFUSED), rsp_data.byte_out == 8'h00, "byte set on a result that carries none")

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (.*);
